### hdl/mrce_pkg.sv
package mrce_pkg;

    localparam int SCREEN_CELLS_DEF    = 2048;
    localparam int COLUMNS_DEF         = 80;
    localparam int NO_REVERSE_FROM_DEF = 1968;

    localparam logic [15:0] LFSR_SEED  = 16'h1C15;
    localparam logic [7:0]  LFSR_TAPS  = 8'hB4;
    localparam logic [7:0]  BLANK_CODE = 8'd32;
    localparam logic [7:0]  CHAR_MASK  = 8'h7F;
    localparam logic [7:0]  REV_BIT    = 8'h80;
    localparam logic [15:0] DRAW_LAST  = 16'hFFFF;

    // Per-column drop record layout
    localparam int HEAD_W  = 14;
    localparam int DROP_W  = HEAD_W + 8 + 8 + 6;

    typedef enum logic [2:0] {
        CFG_GLITCH    = 3'd0,
        CFG_TRAIL_MIN = 3'd1,
        CFG_TRAIL_MAX = 3'd2,
        CFG_REVERSE   = 3'd3,
        CFG_NEWCHAR   = 3'd4,
        CFG_DROPS     = 3'd5,
        CFG_START_SPD = 3'd6,
        CFG_RECYC_SPD = 3'd7
    } cfg_index_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLEAR,
        S_SEED_SPD,
        S_SEED_TRL,
        S_SEED_WR,
        S_DROP_RD,
        S_DROP_LD,
        S_CHK,
        S_NC,
        S_NC2,
        S_HCHAR,
        S_HREV,
        S_HEMIT,
        S_DIM_RD,
        S_DIM,
        S_GL,
        S_GROW,
        S_GCHAR,
        S_MOVE,
        S_ERASE,
        S_REC_HEAD,
        S_REC_SPD,
        S_REC_TRL,
        S_DROP_WR,
        S_FINISH
    } state_t;

    function automatic logic [15:0] lfsr_next(input logic [15:0] s);
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] nlo;
        logic [7:0] nhi;
        lo  = s[7:0];
        hi  = s[15:8];
        nlo = {lo[6:0], hi[0]};
        nhi = {1'b0, hi[7:1]} ^ (lo[7] ? LFSR_TAPS : 8'h00);
        return {nhi, nlo};
    endfunction

    function automatic logic [7:0] to_char(input logic [7:0] v);
        logic [7:0] c;
        c = v & CHAR_MASK;
        return (c == BLANK_CODE) ? 8'd33 : c;
    endfunction

endpackage

### hdl/mrce_ram.sv
module mrce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/matrix_rain_column_engine.sv
// Falling-character engine: keeps its own screen (SCREEN_CELLS bytes) and one drop
// record per column in block RAMs, and reports every column-step screen write as a result.
// After reset a clearing pass over the screen and the drop records runs before the
// first input is taken. A restart clears the screen only, then seeds each configured
// drop with a speed draw, a trail draw and a record write, rerolling an out-of-range draw.
// The LFSR yields one draw per cycle in a drawing state while the output is not stalled,
// and the screen RAM's one read and one write port serialize the reads and writes of a step.
// A result waits in a one-entry pending slot so the final one can carry last.
module matrix_rain_column_engine
#(
    parameter int SCREEN_CELLS    = mrce_pkg::SCREEN_CELLS_DEF,
    parameter int COLUMNS         = mrce_pkg::COLUMNS_DEF,
    parameter int NO_REVERSE_FROM = mrce_pkg::NO_REVERSE_FROM_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [6:0]  column,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        write_valid,
    output logic [10:0] write_address,
    output logic [7:0]  write_data,
    output logic        last,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import mrce_pkg::*;

    localparam int SA_W = $clog2(SCREEN_CELLS);
    localparam int DA_W = $clog2(COLUMNS);
    localparam logic signed [15:0] CELLS_S = 16'(SCREEN_CELLS);
    localparam logic signed [15:0] NRF_S   = 16'(NO_REVERSE_FROM);
    localparam logic signed [15:0] COLS_S  = 16'(COLUMNS);

    state_t state_reg, state_next;
    logic [15:0] lfsr_reg, lfsr_next_v;
    logic [15:0] cnt_reg, cnt_next;
    logic [SA_W-1:0] idx_reg, idx_next;
    logic clr_drops_reg, clr_drops_next;
    logic [DA_W-1:0] col_reg, col_next;
    logic signed [15:0] p_reg, p_next;
    logic [7:0] intv_reg, intv_next;
    logic [7:0] wait_reg, wait_next;
    logic [5:0] trail_reg, trail_next;
    logic [7:0] h_reg, h_next;
    logic nc_reg, nc_next;
    logic [3:0] row_reg, row_next;

    logic [7:0] glitch_reg, reverse_reg, newchar_reg, sspd_reg, rspd_reg;
    logic [4:0] tmin_reg;
    logic [5:0] tmax_reg;
    logic [6:0] drops_reg;

    logic        pend_valid_reg, pend_valid_next;
    logic [10:0] pend_addr_reg, pend_addr_next;
    logic [7:0]  pend_data_reg, pend_data_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_wv_reg, out_wv_next;
    logic [10:0] out_addr_reg, out_addr_next;
    logic [7:0]  out_data_reg, out_data_next;
    logic        out_last_reg, out_last_next;

    logic            s_we;
    logic [SA_W-1:0] s_waddr, s_raddr;
    logic [7:0]      s_wdata, s_rdata;
    logic            d_we;
    logic [DA_W-1:0] d_waddr;
    logic [DROP_W-1:0] d_wdata, d_rdata;

    mrce_ram #(.WIDTH(8), .DEPTH(SCREEN_CELLS)) u_screen (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata)
    );

    mrce_ram #(.WIDTH(DROP_W), .DEPTH(COLUMNS)) u_drops (
        .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
        .raddr(col_reg), .rdata(d_rdata)
    );

    // draw helpers
    logic [15:0] lfsr_step;
    logic [7:0]  rv;
    logic        cap;
    logic [7:0]  sspd_lim, rspd_lim;
    logic [5:0]  trl_n;
    logic        trl_ok, trl_bad;
    logic [6:0]  n_seed, seed_i;
    logic        seed_above;
    logic [HEAD_W-1:0] seed_head;
    logic signed [15:0] dim_a, gl_a, er_a;
    logic        slot_free;
    logic        emit_req;
    logic signed [15:0] emit_addr;
    logic [7:0]  emit_data;

    assign lfsr_step = lfsr_next(lfsr_reg);
    assign rv        = lfsr_step[15:8] ^ lfsr_step[7:0];
    assign cap       = (cnt_reg == DRAW_LAST);
    assign sspd_lim  = (sspd_reg == 8'd0) ? 8'd1 : sspd_reg;
    assign rspd_lim  = (rspd_reg == 8'd0) ? 8'd1 : rspd_reg;
    assign trl_n     = {1'b0, rv[4:0]} + {1'b0, tmin_reg};
    assign trl_ok    = (trl_n <= tmax_reg);
    assign trl_bad   = ({1'b0, tmin_reg} > tmax_reg);
    assign n_seed    = (drops_reg > 7'(COLUMNS)) ? 7'(COLUMNS) : drops_reg;
    assign seed_i    = idx_reg[6:0];
    always_comb
    begin
        seed_above = !seed_i[0] && !((seed_i >= 7'd20 && seed_i <= 7'd29) ||
                                     (seed_i >= 7'd50 && seed_i <= 7'd59));
        if (seed_i == 7'd24 || seed_i == 7'd54)
        begin
            seed_above = 1'b1;
        end
    end
    assign seed_head = seed_above ? (HEAD_W'(seed_i) - HEAD_W'(256)) : HEAD_W'(seed_i);
    assign dim_a     = p_reg - COLS_S;
    assign gl_a      = p_reg - $signed(16'(row_reg) * 16'(COLUMNS));
    assign er_a      = p_reg - $signed(16'(trail_reg) * 16'(COLUMNS));
    assign slot_free = !out_valid_reg || out_ready;

    function automatic logic cell_in_range(input logic signed [15:0] a,
                                           input logic signed [15:0] n);
        return (a >= 16'sd0) && (a < n);
    endfunction

    always_comb
    begin
        state_next      = state_reg;
        lfsr_next_v     = lfsr_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        clr_drops_next  = clr_drops_reg;
        col_next        = col_reg;
        p_next          = p_reg;
        intv_next       = intv_reg;
        wait_next       = wait_reg;
        trail_next      = trail_reg;
        h_next          = h_reg;
        nc_next         = nc_reg;
        row_next        = row_reg;
        s_we            = 1'b0;
        s_waddr         = idx_reg;
        s_wdata         = BLANK_CODE;
        s_raddr         = p_reg[SA_W-1:0];
        d_we            = 1'b0;
        d_waddr         = col_reg;
        d_wdata         = {p_reg[HEAD_W-1:0], intv_reg, wait_reg, trail_reg};
        emit_req        = 1'b0;
        emit_addr       = p_reg;
        emit_data       = h_reg;
        pend_valid_next = pend_valid_reg;
        pend_addr_next  = pend_addr_reg;
        pend_data_next  = pend_data_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_wv_next     = out_wv_reg;
        out_addr_next   = out_addr_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (!op)
                    begin
                        lfsr_next_v    = LFSR_SEED;
                        idx_next       = '0;
                        clr_drops_next = 1'b0;
                        state_next     = S_CLEAR;
                    end
                    else if (column >= 7'(COLUMNS))
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        col_next   = column[DA_W-1:0];
                        state_next = S_DROP_RD;
                    end
                end
            end
            S_CLEAR:
            begin
                s_we = 1'b1;
                if (clr_drops_reg && idx_reg < SA_W'(COLUMNS))
                begin
                    d_we    = 1'b1;
                    d_waddr = idx_reg[DA_W-1:0];
                    d_wdata = '0;
                end
                if (idx_reg == SA_W'(SCREEN_CELLS - 1))
                begin
                    idx_next = '0;
                    cnt_next = '0;
                    if (clr_drops_reg)
                    begin
                        clr_drops_next = 1'b0;
                        state_next     = S_IDLE;
                    end
                    else if (n_seed == 7'd0)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SEED_SPD;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_SEED_SPD, S_REC_SPD:
            begin
                lfsr_next_v = lfsr_step;
                cnt_next    = cnt_reg + 1'b1;
                if ((state_reg == S_SEED_SPD ? rv < sspd_lim : rv < rspd_lim) || cap)
                begin
                    intv_next  = ((state_reg == S_SEED_SPD ? rv < sspd_lim : rv < rspd_lim))
                                 ? rv : 8'd0;
                    cnt_next   = '0;
                    state_next = (state_reg == S_SEED_SPD) ? S_SEED_TRL : S_REC_TRL;
                end
            end
            S_SEED_TRL, S_REC_TRL:
            begin
                lfsr_next_v = lfsr_step;
                cnt_next    = cnt_reg + 1'b1;
                if (trl_bad || trl_ok || cap)
                begin
                    trail_next = (!trl_bad && trl_ok) ? trl_n : tmax_reg;
                    cnt_next   = '0;
                    state_next = (state_reg == S_SEED_TRL) ? S_SEED_WR : S_DROP_WR;
                end
            end
            S_SEED_WR:
            begin
                d_we    = 1'b1;
                d_waddr = idx_reg[DA_W-1:0];
                d_wdata = {seed_head, intv_reg, 8'd0, trail_reg};
                if (seed_i == n_seed - 7'd1)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SEED_SPD;
                end
            end
            S_DROP_RD:
            begin
                state_next = S_DROP_LD;
            end
            S_DROP_LD:
            begin
                p_next     = 16'($signed(d_rdata[DROP_W-1 -: HEAD_W]));
                intv_next  = d_rdata[21:14];
                wait_next  = d_rdata[13:6];
                trail_next = d_rdata[5:0];
                state_next = S_CHK;
            end
            S_CHK:
            begin
                state_next = cell_in_range(p_reg, CELLS_S) ? S_NC : S_MOVE;
            end
            S_NC:
            begin
                lfsr_next_v = lfsr_step;
                nc_next     = (rv < newchar_reg);
                state_next  = S_NC2;
            end
            S_NC2:
            begin
                if (nc_reg || s_rdata == BLANK_CODE)
                begin
                    state_next = S_HCHAR;
                end
                else
                begin
                    h_next     = s_rdata;
                    state_next = S_HEMIT;
                end
            end
            S_HCHAR:
            begin
                lfsr_next_v = lfsr_step;
                h_next      = to_char(rv);
                state_next  = S_HREV;
            end
            S_HREV:
            begin
                lfsr_next_v = lfsr_step;
                if (rv < reverse_reg)
                begin
                    h_next = h_reg | REV_BIT;
                end
                state_next = S_HEMIT;
            end
            S_HEMIT:
            begin
                emit_req  = 1'b1;
                emit_data = (p_reg >= NRF_S) ? (h_reg & CHAR_MASK) : h_reg;
                if (slot_free)
                begin
                    state_next = cell_in_range(dim_a, CELLS_S) ? S_DIM_RD : S_MOVE;
                end
            end
            S_DIM_RD:
            begin
                s_raddr    = dim_a[SA_W-1:0];
                state_next = S_DIM;
            end
            S_DIM:
            begin
                // keep the row-above cell on the read port while the output stalls
                s_raddr   = dim_a[SA_W-1:0];
                emit_req  = 1'b1;
                emit_addr = dim_a;
                emit_data = s_rdata & CHAR_MASK;
                if (slot_free)
                begin
                    state_next = S_GL;
                end
            end
            S_GL:
            begin
                lfsr_next_v = lfsr_step;
                state_next  = (rv < glitch_reg) ? S_GROW : S_MOVE;
            end
            S_GROW:
            begin
                lfsr_next_v = lfsr_step;
                row_next    = rv[3:0];
                state_next  = (rv[3:0] != 4'd0 && {2'b00, rv[3:0]} < trail_reg)
                              ? S_GCHAR : S_MOVE;
            end
            S_GCHAR:
            begin
                if (!cell_in_range(gl_a, CELLS_S))
                begin
                    state_next = S_MOVE;
                end
                else
                begin
                    emit_req  = 1'b1;
                    emit_addr = gl_a;
                    emit_data = to_char(rv);
                    if (slot_free)
                    begin
                        lfsr_next_v = lfsr_step;
                        state_next  = S_MOVE;
                    end
                end
            end
            S_MOVE:
            begin
                if (wait_reg != intv_reg)
                begin
                    wait_next  = wait_reg + 1'b1;
                    state_next = S_DROP_WR;
                end
                else
                begin
                    wait_next = 8'd0;
                    if (er_a >= CELLS_S)
                    begin
                        cnt_next   = '0;
                        state_next = S_REC_HEAD;
                    end
                    else if (er_a >= 16'sd0)
                    begin
                        state_next = S_ERASE;
                    end
                    else
                    begin
                        p_next     = p_reg + COLS_S;
                        state_next = S_DROP_WR;
                    end
                end
            end
            S_ERASE:
            begin
                emit_req  = 1'b1;
                emit_addr = er_a;
                emit_data = BLANK_CODE;
                if (slot_free)
                begin
                    p_next     = p_reg + COLS_S;
                    state_next = S_DROP_WR;
                end
            end
            S_REC_HEAD:
            begin
                lfsr_next_v = lfsr_step;
                cnt_next    = cnt_reg + 1'b1;
                if (rv < 8'(COLUMNS) || cap)
                begin
                    p_next     = (rv < 8'(COLUMNS)) ? 16'(rv) : 16'sd0;
                    cnt_next   = '0;
                    state_next = S_REC_SPD;
                end
            end
            S_DROP_WR:
            begin
                d_we       = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_wv_next     = pend_valid_reg;
                    out_addr_next   = pend_valid_reg ? pend_addr_reg : 11'd0;
                    out_data_next   = pend_valid_reg ? pend_data_reg : 8'd0;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a new write pushes the previous one out; the last one stays pending
        if (emit_req && slot_free)
        begin
            s_we    = 1'b1;
            s_waddr = emit_addr[SA_W-1:0];
            s_wdata = emit_data;
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_wv_next    = 1'b1;
                out_addr_next  = pend_addr_reg;
                out_data_next  = pend_data_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_addr_next  = emit_addr[10:0];
            pend_data_next  = emit_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            lfsr_reg       <= LFSR_SEED;
            cnt_reg        <= '0;
            idx_reg        <= '0;
            clr_drops_reg  <= 1'b1;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            glitch_reg     <= 8'd64;
            tmin_reg       <= 5'd10;
            tmax_reg       <= 6'd24;
            reverse_reg    <= 8'd64;
            newchar_reg    <= 8'd51;
            drops_reg      <= 7'd70;
            sspd_reg       <= 8'd9;
            rspd_reg       <= 8'd5;
        end
        else
        begin
            state_reg      <= state_next;
            lfsr_reg       <= lfsr_next_v;
            cnt_reg        <= cnt_next;
            idx_reg        <= idx_next;
            clr_drops_reg  <= clr_drops_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_GLITCH:    glitch_reg  <= cfg_data;
                    CFG_TRAIL_MIN: tmin_reg    <= cfg_data[4:0];
                    CFG_TRAIL_MAX: tmax_reg    <= cfg_data[5:0];
                    CFG_REVERSE:   reverse_reg <= cfg_data;
                    CFG_NEWCHAR:   newchar_reg <= cfg_data;
                    CFG_DROPS:     drops_reg   <= cfg_data[6:0];
                    CFG_START_SPD: sspd_reg    <= cfg_data;
                    CFG_RECYC_SPD: rspd_reg    <= cfg_data;
                    default:       glitch_reg  <= glitch_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg       <= col_next;
        p_reg         <= p_next;
        intv_reg      <= intv_next;
        wait_reg      <= wait_next;
        trail_reg     <= trail_next;
        h_reg         <= h_next;
        nc_reg        <= nc_next;
        row_reg       <= row_next;
        pend_addr_reg <= pend_addr_next;
        pend_data_reg <= pend_data_next;
        out_wv_reg    <= out_wv_next;
        out_addr_reg  <= out_addr_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign write_valid   = out_wv_reg;
    assign write_address = out_addr_reg;
    assign write_data    = out_data_reg;
    assign last          = out_last_reg;

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !pend_valid_reg)
        else $error("pending write left over at idle");

    a_null_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_wv_reg) |-> out_last_reg)
        else $error("empty result without last");

    a_finish_pushes_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && slot_free) |=> (out_valid_reg && out_last_reg))
        else $error("finish did not present the final result");

    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !emit_req)
        else $error("screen write during clearing pass");

endmodule
